FILE: rtl/assert_macros.svh
// assertion macros shared by the interval set rtl
// depends on nothing; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

// invariant checked at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

FILE: rtl/isim_pkg.sv
// shared constants and types for the interval set insert/merge block
// depends on nothing; used by every module of the block
package isim_pkg;

    // default table depth and value width
    localparam int MAX_RANGES_DEF = 16;
    localparam int VALUE_BITS_DEF = 16;

    // width of the range count field on the result
    localparam int COUNT_BITS = 5;

    // which searches found a slot
    typedef struct packed {
        logic hold;
        logic left;
        logic right;
        logic free;
    } hit_t;

endpackage

FILE: rtl/interval_set_insert_merge.sv
// Interval set insert/merge: input register, single-pass table update, result register.
// An accepted transaction passes through the input register and then the result register, which drives m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; all slots are compared in parallel.
// Reset (rst_n low, asynchronous): table emptied, range count zero, both stages empty.
// depends on isim_pkg, isim_table and assert_macros.svh
`include "assert_macros.svh"

module interval_set_insert_merge #(
    parameter int MAX_RANGES = isim_pkg::MAX_RANGES_DEF,
    parameter int VALUE_BITS = isim_pkg::VALUE_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // input stream
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]     s_tdata,  // value
    input  logic                                        s_tuser,  // start_fresh
    // result stream
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((isim_pkg::COUNT_BITS + 2 * VALUE_BITS + 7) / 8) * 8 - 1:0]
                                                        m_tdata,  // range_count, hold_start, hold_end
    output logic                                        m_tuser   // dropped
);

    localparam int OUT_W = ((isim_pkg::COUNT_BITS + 2 * VALUE_BITS + 7) / 8) * 8;

    logic                  in_valid_reg;
    logic [VALUE_BITS-1:0] in_value_reg;
    logic                  in_fresh_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  proc;

    logic [isim_pkg::COUNT_BITS-1:0] range_count;
    logic [VALUE_BITS-1:0]           hold_start;
    logic [VALUE_BITS-1:0]           hold_end;
    logic                            dropped;

    // item in the input register moves on when the result register is free
    assign proc     = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    isim_table #(
        .MAX_RANGES (MAX_RANGES),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (proc),
        .value       (in_value_reg),
        .fresh       (in_fresh_reg),
        .range_count (range_count),
        .hold_start  (hold_start),
        .hold_end    (hold_end),
        .dropped     (dropped)
    );

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (proc)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_value_reg <= s_tdata[VALUE_BITS-1:0];
            in_fresh_reg <= s_tuser;
        end
        if (proc)
        begin
            m_tdata_reg <= OUT_W'({hold_end, hold_start, range_count});
            m_tuser_reg <= dropped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // every processed item shows up as a result in the next cycle
    `ASSERT_NEXT(a_proc_result, clk, rst_n, proc, m_tvalid_reg, "processed item produced no result")

endmodule

FILE: rtl/isim_match.sv
// parallel compare of one value against every slot of the range table
// depends on isim_pkg; instantiated by isim_table
module isim_match #(
    parameter int MAX_RANGES = isim_pkg::MAX_RANGES_DEF,
    parameter int VALUE_BITS = isim_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0] value,
    input  logic [MAX_RANGES-1:0] slot_valid,
    input  logic [VALUE_BITS-1:0] slot_start [MAX_RANGES],
    input  logic [VALUE_BITS-1:0] slot_end   [MAX_RANGES],
    output isim_pkg::hit_t        hit,
    output logic [MAX_RANGES-1:0] hold_sel,
    output logic [MAX_RANGES-1:0] left_sel,
    output logic [MAX_RANGES-1:0] right_sel,
    output logic [MAX_RANGES-1:0] free_sel,
    output logic [VALUE_BITS-1:0] hold_start,
    output logic [VALUE_BITS-1:0] hold_end,
    output logic [VALUE_BITS-1:0] left_start,
    output logic [VALUE_BITS-1:0] right_end
);

    logic [VALUE_BITS-1:0] value_dec;
    logic [VALUE_BITS-1:0] value_inc;
    logic                  has_left;
    logic                  has_right;
    logic [MAX_RANGES-1:0] hold_vec;
    logic [MAX_RANGES-1:0] left_vec;
    logic [MAX_RANGES-1:0] right_vec;
    logic [MAX_RANGES-1:0] free_vec;

    // neighbors of the value, guarded at both ends of the value range
    assign value_dec = value - VALUE_BITS'(1);
    assign value_inc = value + VALUE_BITS'(1);
    assign has_left  = (value != '0);
    assign has_right = (value != '1);

    // per-slot compares
    always_comb
    begin
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            hold_vec[i]  = slot_valid[i] && (value >= slot_start[i]) && (value <= slot_end[i]);
            left_vec[i]  = slot_valid[i] && has_left && (slot_end[i] == value_dec);
            right_vec[i] = slot_valid[i] && has_right && (slot_start[i] == value_inc);
            free_vec[i]  = !slot_valid[i];
        end
    end

    // lowest slot wins each search
    assign hold_sel  = hold_vec  & (~hold_vec  + MAX_RANGES'(1));
    assign left_sel  = left_vec  & (~left_vec  + MAX_RANGES'(1));
    assign right_sel = right_vec & (~right_vec + MAX_RANGES'(1));
    assign free_sel  = free_vec  & (~free_vec  + MAX_RANGES'(1));

    assign hit.hold  = |hold_vec;
    assign hit.left  = |left_vec;
    assign hit.right = |right_vec;
    assign hit.free  = |free_vec;

    // and-or pick of the bounds of the matching slots
    always_comb
    begin
        hold_start = '0;
        hold_end   = '0;
        left_start = '0;
        right_end  = '0;
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            hold_start = hold_start | (slot_start[i] & {VALUE_BITS{hold_sel[i]}});
            hold_end   = hold_end   | (slot_end[i]   & {VALUE_BITS{hold_sel[i]}});
            left_start = left_start | (slot_start[i] & {VALUE_BITS{left_sel[i]}});
            right_end  = right_end  | (slot_end[i]   & {VALUE_BITS{right_sel[i]}});
        end
    end

endmodule

FILE: rtl/isim_table.sv
// range table registers and the insert/merge update
// depends on isim_pkg, isim_match and assert_macros.svh; instantiated by the top level
`include "assert_macros.svh"

module isim_table #(
    parameter int MAX_RANGES = isim_pkg::MAX_RANGES_DEF,
    parameter int VALUE_BITS = isim_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [VALUE_BITS-1:0]           value,
    input  logic                            fresh,
    output logic [isim_pkg::COUNT_BITS-1:0] range_count,
    output logic [VALUE_BITS-1:0]           hold_start,
    output logic [VALUE_BITS-1:0]           hold_end,
    output logic                            dropped
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    logic [VALUE_BITS-1:0] slot_start_reg  [MAX_RANGES];
    logic [VALUE_BITS-1:0] slot_end_reg    [MAX_RANGES];
    logic [VALUE_BITS-1:0] slot_start_next [MAX_RANGES];
    logic [VALUE_BITS-1:0] slot_end_next   [MAX_RANGES];
    logic [MAX_RANGES-1:0] slot_valid_reg;
    logic [MAX_RANGES-1:0] slot_valid_next;
    logic [CNT_W-1:0]      live_reg;
    logic [CNT_W-1:0]      live_next;

    logic [MAX_RANGES-1:0] valid_eff;
    logic [CNT_W-1:0]      live_eff;

    isim_pkg::hit_t        hit;
    logic [MAX_RANGES-1:0] hold_sel;
    logic [MAX_RANGES-1:0] left_sel;
    logic [MAX_RANGES-1:0] right_sel;
    logic [MAX_RANGES-1:0] free_sel;
    logic [VALUE_BITS-1:0] m_hold_start;
    logic [VALUE_BITS-1:0] m_hold_end;
    logic [VALUE_BITS-1:0] m_left_start;
    logic [VALUE_BITS-1:0] m_right_end;

    // start fresh empties the table ahead of the search
    assign valid_eff = fresh ? '0 : slot_valid_reg;
    assign live_eff  = fresh ? '0 : live_reg;

    isim_match #(
        .MAX_RANGES (MAX_RANGES),
        .VALUE_BITS (VALUE_BITS)
    ) u_match (
        .value      (value),
        .slot_valid (valid_eff),
        .slot_start (slot_start_reg),
        .slot_end   (slot_end_reg),
        .hit        (hit),
        .hold_sel   (hold_sel),
        .left_sel   (left_sel),
        .right_sel  (right_sel),
        .free_sel   (free_sel),
        .hold_start (m_hold_start),
        .hold_end   (m_hold_end),
        .left_start (m_left_start),
        .right_end  (m_right_end)
    );

    // next table contents and the result of this insert
    always_comb
    begin
        slot_start_next = slot_start_reg;
        slot_end_next   = slot_end_reg;
        slot_valid_next = valid_eff;
        live_next       = live_eff;
        hold_start      = '0;
        hold_end        = '0;
        dropped         = 1'b0;
        if (hit.hold)
        begin
            hold_start = m_hold_start;
            hold_end   = m_hold_end;
        end
        else if (hit.left && hit.right)
        begin
            // bridge two ranges: left takes over, right slot is freed
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                if (left_sel[i])
                begin
                    slot_end_next[i] = m_right_end;
                end
                if (right_sel[i])
                begin
                    slot_valid_next[i] = 1'b0;
                end
            end
            live_next  = live_eff - CNT_W'(1);
            hold_start = m_left_start;
            hold_end   = m_right_end;
        end
        else if (hit.left)
        begin
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                if (left_sel[i])
                begin
                    slot_end_next[i] = value;
                end
            end
            hold_start = m_left_start;
            hold_end   = value;
        end
        else if (hit.right)
        begin
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                if (right_sel[i])
                begin
                    slot_start_next[i] = value;
                end
            end
            hold_start = value;
            hold_end   = m_right_end;
        end
        else if (hit.free)
        begin
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                if (free_sel[i])
                begin
                    slot_start_next[i] = value;
                    slot_end_next[i]   = value;
                    slot_valid_next[i] = 1'b1;
                end
            end
            live_next  = live_eff + CNT_W'(1);
            hold_start = value;
            hold_end   = value;
        end
        else
        begin
            dropped = 1'b1;
        end
    end

    assign range_count = isim_pkg::COUNT_BITS'(live_next);

    // slot valid bits and live count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            live_reg       <= '0;
        end
        else if (en)
        begin
            slot_valid_reg <= slot_valid_next;
            live_reg       <= live_next;
        end
    end

    // slot bounds, only read while the slot is valid
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slot_start_reg <= slot_start_next;
            slot_end_reg   <= slot_end_next;
        end
    end

    // live count tracks the number of valid slots
    `ASSERT_ALWAYS(a_live_count, clk, rst_n, $countones(slot_valid_reg) == int'(live_reg), "live count differs from valid slots")

    // a value inside a range never has a touching neighbor range
    `ASSERT_IMPL(a_hold_alone, clk, rst_n, en && hit.hold, !hit.left && !hit.right, "held value has a touching neighbor")

    // a drop only happens with every slot in use
    `ASSERT_IMPL(a_drop_full, clk, rst_n, en && dropped, live_reg == CNT_W'(MAX_RANGES), "drop with a free slot")

endmodule

FILE: bench/tb_interval_set_insert_merge.sv
// testbench for interval_set_insert_merge: directed table plus random inserts,
// each result checked against a local model of the range table or a directed expected value
// depends on isim_pkg and the interval_set_insert_merge rtl
module tb_interval_set_insert_merge;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = isim_pkg::MAX_RANGES_DEF;
    localparam int VBITS      = isim_pkg::VALUE_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 1500;
    localparam logic [VBITS-1:0] VALUE_TOP = '1;

    // one result transaction: range count, hold start, hold end and dropped flag
    typedef struct packed {
        logic [isim_pkg::COUNT_BITS-1:0] count;
        logic [VBITS-1:0]                first;
        logic [VBITS-1:0]                last;
        logic                            drop;
    } span_result_t;

    // one row of the directed stimulus
    typedef struct {
        logic [VBITS-1:0] value;
        bit               fresh;
        bit               typed;
        span_result_t     want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // value
    logic        s_tuser;   // start_fresh
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // range_count, hold_start, hold_end, zero pad
    logic        m_tuser;   // dropped

    // local copy of the range table
    logic [VBITS-1:0]                span_lo [SLOTS];
    logic [VBITS-1:0]                span_hi [SLOTS];
    bit                              span_used [SLOTS];
    logic [isim_pkg::COUNT_BITS-1:0] span_total;

    span_result_t expected_holds[$];
    stim_row_t    directed_rows[$];

    int  fail_count;
    int  shown_count;
    int  results_seen;
    int  idle_cycles;
    bit  calm;
    int  n_held, n_merge, n_grow, n_new, n_drop, n_fresh;

    interval_set_insert_merge dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // insert one value into the local table and return the result it gives
    function automatic span_result_t insert_value(input logic [VBITS-1:0] v, input bit fresh);
        int           hold_idx, left_idx, right_idx, free_idx;
        span_result_t res;
        hold_idx  = -1;
        left_idx  = -1;
        right_idx = -1;
        free_idx  = -1;
        res       = '0;
        if (fresh)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                span_lo[i]   = '0;
                span_hi[i]   = '0;
                span_used[i] = 1'b0;
            end
            span_total = '0;
            n_fresh++;
        end
        // search all slots, lowest index wins
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!span_used[i])
            begin
                if (free_idx < 0)
                    free_idx = i;
            end
            else
            begin
                if (hold_idx < 0 && v >= span_lo[i] && v <= span_hi[i])
                    hold_idx = i;
                if (left_idx < 0 && v != '0 && span_hi[i] == v - 1'b1)
                    left_idx = i;
                if (right_idx < 0 && v != VALUE_TOP && span_lo[i] == v + 1'b1)
                    right_idx = i;
            end
        end
        if (hold_idx >= 0)
        begin
            res.first = span_lo[hold_idx];
            res.last  = span_hi[hold_idx];
            n_held++;
        end
        else if (left_idx >= 0 && right_idx >= 0)
        begin
            // bridge two ranges, the right one's slot is freed
            span_hi[left_idx]    = span_hi[right_idx];
            span_used[right_idx] = 1'b0;
            span_lo[right_idx]   = '0;
            span_hi[right_idx]   = '0;
            if (span_total != '0)
                span_total = span_total - 1'b1;
            res.first = span_lo[left_idx];
            res.last  = span_hi[left_idx];
            n_merge++;
        end
        else if (left_idx >= 0)
        begin
            span_hi[left_idx] = v;
            res.first = span_lo[left_idx];
            res.last  = v;
            n_grow++;
        end
        else if (right_idx >= 0)
        begin
            span_lo[right_idx] = v;
            res.first = v;
            res.last  = span_hi[right_idx];
            n_grow++;
        end
        else if (free_idx >= 0)
        begin
            span_lo[free_idx]   = v;
            span_hi[free_idx]   = v;
            span_used[free_idx] = 1'b1;
            span_total = span_total + 1'b1;
            res.first = v;
            res.last  = v;
            n_new++;
        end
        else
        begin
            res.drop = 1'b1;
            n_drop++;
        end
        res.count = span_total;
        return res;
    endfunction

    // idle length: mostly short, now and then long, none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    task automatic add_row(input logic [VBITS-1:0] v, input bit fresh, input bit typed,
                           input int cnt, input int first, input int last, input bit drop);
        stim_row_t row;
        row.value = v;
        row.fresh = fresh;
        row.typed = typed;
        row.want  = '{cnt[isim_pkg::COUNT_BITS-1:0], first[VBITS-1:0], last[VBITS-1:0], drop};
        directed_rows = {directed_rows, row};
    endtask

    // drive one input transaction, entered and left at a falling edge
    task automatic send_item(input logic [VBITS-1:0] v, input bit fresh, input bit typed,
                             input span_result_t want);
        int           gap;
        span_result_t predicted;
        span_result_t queued;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= fresh;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = insert_value(v, fresh);
        queued    = typed ? want : predicted;
        expected_holds = {expected_holds, queued};
        @(negedge clk);
    endtask

    // result side back-pressure
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        span_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[4:0], m_tdata[20:5], m_tdata[36:21], m_tuser};
            results_seen++;
            if (expected_holds.size() == 0)
            begin
                fail_count++;
                if (shown_count < 10)
                begin
                    shown_count++;
                    $display("unexpected result: count=%0d start=%h end=%h dropped=%b",
                             got.count, got.first, got.last, got.drop);
                end
            end
            else
            begin
                want = expected_holds.pop_front();
                if (got.count !== want.count || got.first !== want.first ||
                    got.last !== want.last || got.drop !== want.drop)
                begin
                    fail_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display("mismatch #%0d: exp count=%0d start=%h end=%h dropped=%b",
                                 results_seen, want.count, want.first, want.last, want.drop);
                        $display("               got count=%0d start=%h end=%h dropped=%b",
                                 got.count, got.first, got.last, got.drop);
                    end
                end
            end
        end
    end

    // cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        @(posedge clk);
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("tb_interval_set_insert_merge: FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        int               base, width, pick;
        logic [VBITS-1:0] v;
        bit               fresh;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        calm        = 1'b0;
        fail_count  = 0;
        shown_count = 0;
        results_seen = 0;
        idle_cycles = 0;
        {n_held, n_merge, n_grow, n_new, n_drop, n_fresh} = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            span_lo[i]   = '0;
            span_hi[i]   = '0;
            span_used[i] = 1'b0;
        end
        span_total = '0;

        // directed: extremes, grow both ways, merge, held, fresh, full table
        add_row(16'h0000, 0, 1, 1, 16'h0000, 16'h0000, 0);
        add_row(16'hFFFF, 0, 1, 2, 16'hFFFF, 16'hFFFF, 0);
        add_row(16'h0001, 0, 0, 0, 0, 0, 0);
        add_row(16'hFFFE, 0, 0, 0, 0, 0, 0);
        add_row(16'h0003, 0, 0, 0, 0, 0, 0);
        add_row(16'h0002, 0, 0, 0, 0, 0, 0);
        add_row(16'h0002, 0, 0, 0, 0, 0, 0);
        add_row(16'hFFFF, 0, 0, 0, 0, 0, 0);
        add_row(16'h0005, 1, 1, 1, 16'h0005, 16'h0005, 0);
        add_row(16'd100, 1, 1, 1, 16'd100, 16'd100, 0);
        for (int k = 1; k < SLOTS; k++)
            add_row(VBITS'(100 + 2 * k), 0, 0, 0, 0, 0, 0);
        add_row(16'd140, 0, 1, SLOTS, 0, 0, 1);
        add_row(16'd101, 0, 0, 0, 0, 0, 0);
        add_row(16'd140, 0, 0, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].value, directed_rows[i].fresh,
                      directed_rows[i].typed, directed_rows[i].want);

        // random: values clustered in a moving window so ranges grow, merge and fill
        base  = 0;
        width = 48;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            fresh = ($urandom_range(99) < 2);
            if (n % 150 == 0)
                calm = ($urandom_range(3) == 0);
            if (n % 60 == 0)
            begin
                pick  = $urandom_range(2);
                width = (pick == 0) ? 24 : (pick == 1) ? 48 : 200;
                pick  = $urandom_range(9);
                if (pick == 0)
                    base = 0;
                else if (pick == 1)
                    base = 65535 - width;
                else
                    base = $urandom_range(65535 - width);
                if ($urandom_range(1))
                    fresh = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 80)
                v = VBITS'(base + $urandom_range(width));
            else if (pick < 90)
                v = VBITS'($urandom);
            else if (pick < 95)
                v = VBITS'($urandom_range(3));
            else
                v = VALUE_TOP - VBITS'($urandom_range(3));
            send_item(v, fresh, 0, '0);
        end
        s_tvalid <= 1'b0;

        // drain
        while (expected_holds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("inserts: %0d results, %0d already held, %0d merges, %0d grows, %0d new",
                 results_seen, n_held, n_merge, n_grow, n_new);
        $display("         %0d dropped on a full table, %0d table clears, %0d failures",
                 n_drop, n_fresh, fail_count);
        if (fail_count == 0)
            $display("tb_interval_set_insert_merge: PASS");
        else
            $display("tb_interval_set_insert_merge: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/isim_pkg.sv
rtl/isim_match.sv
rtl/isim_table.sv
rtl/interval_set_insert_merge.sv
bench/tb_interval_set_insert_merge.sv
